// File: hdl/lazy_segment_tree_range_sum_macros.svh
// Assertion macros for the lazy segment tree range-sum block.
// Included by modules that assert; expects clk_i and rst_ni in scope.
`ifndef LAZY_SEGMENT_TREE_RANGE_SUM_MACROS_SVH
`define LAZY_SEGMENT_TREE_RANGE_SUM_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define LSTRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define LSTRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lstrs_pkg.sv
// Shared types and constants for the lazy segment tree range-sum block.
// No dependencies.
`default_nettype none

package lstrs_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned SUM_W = 64;
  localparam int unsigned CFG_W = 11;

  localparam logic [CFG_W-1:0] LEN_RESET = 11'd1024;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  // Request codes; the fourth code is unused and rejected
  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_MOD,
    ST_FIN,
    ST_DONE
  } state_e;

  // Kinds of root-to-leaf walk
  typedef enum logic [1:0] {
    WK_PREFIX_SUM,
    WK_PREFIX_ADD,
    WK_POINT_READ,
    WK_POINT_ADD
  } walk_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        range_low;
    logic [IDX_W-1:0]        range_high;
    logic signed [VAL_W-1:0] operand_value;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic                    status;
  } out_t;

endpackage

`default_nettype wire

// File: hdl/lazy_segment_tree_range_sum.sv
// Top level of the lazy segment tree range-sum block: sequencer and node stores.
// Depends on lstrs_pkg and lazy_segment_tree_range_sum_macros.svh.
`default_nettype none

// Range-add / range-sum engine over MAX_ELEMENTS signed elements, sums wrapping
// in 64 bits. Node sums and pending adds live in two single-port-read memories
// of 2*SPAN entries (SPAN = MAX_ELEMENTS rounded up to a power of two). Every
// request that is in range is one or two root-to-leaf walks: a range add is
// one or two prefix adds, a query one prefix sum or the difference of two, a
// set a point read then a point add. Each tree level passes through read,
// modify/write and write back of the left child. Bad requests skip the walks
// and go straight to the result. After reset a clearing pass zeroes all
// 2*SPAN entries of both memories, during which no request is taken; the length
// register may be written at any time. One request is in flight at a time; a
// finished result waits in the output register while the next one is taken.
module lazy_segment_tree_range_sum #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire lstrs_pkg::in_t           in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output lstrs_pkg::out_t               out_data_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [lstrs_pkg::CFG_W-1:0] cfg_data_i
);
  import lstrs_pkg::*;

  localparam int unsigned LEVELS = $clog2(MAX_ELEMENTS);
  localparam int unsigned SPAN   = 2 ** LEVELS;
  localparam int unsigned DEPTH  = 2 * SPAN;
  localparam int unsigned NW     = LEVELS + 1;
  localparam int unsigned LW     = $clog2(LEVELS + 1);
  localparam int unsigned MW     = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CW     = ((MW > CFG_W) ? MW : CFG_W) + 1;
  localparam int unsigned PW     = 35 + LEVELS;

  // Control state
  state_e            state_q, state_d;
  walk_e             walk_q, walk_d;
  logic              second_q, second_d;
  logic              sub_q, sub_d;
  logic              bad_q, bad_d;
  logic [NW-1:0]     clr_q, clr_d;
  logic [NW-1:0]     node_q, node_d;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic [CFG_W-1:0]  len_q;
  logic              out_valid_q;
  // Walk payload
  logic [LEVELS-1:0] x_q, x_d;
  logic [LEVELS-1:0] xs_q, xs_d;
  logic [LEVELS-1:0] nx_q, nx_d;
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic [SUM_W-1:0]  res_q, res_d;
  logic [SUM_W-1:0]  val_q, val_d;
  logic [SUM_W-1:0]  prod_q, prod_d;
  logic [VAL_W-1:0]  opv_q, opv_d;
  out_t              out_q;

  // Memories and their ports
  logic [SUM_W-1:0]  sums_mem [DEPTH];
  logic [SUM_W-1:0]  tags_mem [DEPTH];
  logic [SUM_W-1:0]  rd_sum_q, rd_tag_q;
  logic [NW-1:0]     sums_raddr, tags_raddr, sums_waddr, tags_waddr;
  logic              sums_we, tags_we;
  logic [SUM_W-1:0]  sums_wdata, tags_wdata;

  // Request decode
  logic [CW-1:0]     a_ext, b_ext, am1_ext, len_eff;
  logic              req_bad;
  logic              load_out;

  // Walk helpers
  logic [NW-1:0]         child0, child;
  logic                  dir, leaf;
  logic [LW-1:0]         sh;
  logic [LEVELS-1:0]     mask;
  logic [LEVELS:0]       overlap;
  logic signed [PW-1:0]  prod_w;
  logic [SUM_W-1:0]      term;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Bound the request against the usable length
  always_comb begin
    a_ext   = CW'(in_data_i.range_low);
    b_ext   = CW'(in_data_i.range_high);
    am1_ext = a_ext - CW'(1);
    len_eff = (CW'(len_q) > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : CW'(len_q);
    case (in_data_i.action)
      ACT_SET:   req_bad = (a_ext >= len_eff);
      ACT_ADD,
      ACT_QUERY: req_bad = (b_ext < a_ext) || (b_ext >= len_eff);
      default:   req_bad = 1'b1;
    endcase
  end

  // Position of the walk in the tree
  assign child0  = {node_q[NW-2:0], 1'b0};
  assign dir     = xs_q[LEVELS-1];
  assign child   = {node_q[NW-2:0], dir};
  assign leaf    = (lvl_q == '0);
  assign sh      = lvl_q - LW'(1);
  assign mask    = ~({LEVELS{1'b1}} << lvl_q);
  assign overlap = {1'b0, x_q & mask} + (LEVELS + 1)'(1);
  assign prod_w  = $signed(val_q[VAL_W:0]) * $signed({1'b0, overlap});

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = req_bad ? ST_DONE : ST_RD;
      ST_RD:    state_d = ST_MOD;
      ST_MOD:   state_d = ST_FIN;
      ST_FIN: begin
        if (leaf && !second_q) state_d = ST_DONE;
        else                   state_d = ST_RD;
      end
      ST_DONE:  if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    walk_d     = walk_q;
    second_d   = second_q;
    sub_d      = sub_q;
    bad_d      = bad_q;
    clr_d      = clr_q;
    node_d     = node_q;
    lvl_d      = lvl_q;
    x_d        = x_q;
    xs_d       = xs_q;
    nx_d       = nx_q;
    acc_d      = acc_q;
    res_d      = res_q;
    val_d      = val_q;
    prod_d     = prod_q;
    opv_d      = opv_q;
    sums_raddr = node_q;
    tags_raddr = node_q;
    sums_we    = 1'b0;
    tags_we    = 1'b0;
    sums_waddr = node_q;
    tags_waddr = child0;
    sums_wdata = '0;
    tags_wdata = '0;
    term       = rd_sum_q + acc_q;
    case (state_q)
      // Zero one entry of each store per cycle
      ST_CLEAR: begin
        sums_we    = 1'b1;
        tags_we    = 1'b1;
        sums_waddr = clr_q;
        tags_waddr = clr_q;
        clr_d      = clr_q + NW'(1);
      end
      // Plan the walks of a new request
      ST_IDLE: begin
        if (in_valid_i) begin
          bad_d  = req_bad;
          node_d = NW'(1);
          lvl_d  = LW'(LEVELS);
          acc_d  = '0;
          res_d  = '0;
          sub_d  = 1'b0;
          opv_d  = in_data_i.operand_value;
          val_d  = {{(SUM_W-VAL_W){in_data_i.operand_value[VAL_W-1]}},
                    in_data_i.operand_value};
          nx_d   = am1_ext[LEVELS-1:0];
          x_d    = b_ext[LEVELS-1:0];
          xs_d   = b_ext[LEVELS-1:0];
          second_d = (a_ext != '0);
          case (in_data_i.action)
            ACT_SET: begin
              walk_d   = WK_POINT_READ;
              x_d      = a_ext[LEVELS-1:0];
              xs_d     = a_ext[LEVELS-1:0];
              nx_d     = a_ext[LEVELS-1:0];
              second_d = 1'b1;
            end
            ACT_ADD: walk_d = WK_PREFIX_ADD;
            default: walk_d = WK_PREFIX_SUM;
          endcase
        end
      end
      // Issue node reads; form the covered-length product
      ST_RD: begin
        if (walk_q == WK_PREFIX_ADD) tags_raddr = child0;
        prod_d = SUM_W'(prod_w);
      end
      // Update or accumulate the node on the path; fetch the left child's sum
      ST_MOD: begin
        sums_raddr = child0;
        case (walk_q)
          WK_PREFIX_ADD: begin
            sums_we    = 1'b1;
            sums_wdata = rd_sum_q + prod_q;
            if (!leaf && dir) begin
              tags_we    = 1'b1;
              tags_wdata = rd_tag_q + val_q;
            end
          end
          WK_POINT_ADD: begin
            sums_we    = 1'b1;
            sums_wdata = rd_sum_q + val_q;
          end
          WK_POINT_READ: begin
            acc_d = acc_q + (leaf ? rd_sum_q : rd_tag_q);
          end
          default: begin
            if (leaf) res_d = sub_q ? res_q - term : res_q + term;
            else      acc_d = acc_q + rd_tag_q;
          end
        endcase
      end
      // Settle the left child, then descend or start the second walk
      ST_FIN: begin
        term = rd_sum_q + (acc_q << sh);
        if (!leaf && dir) begin
          if (walk_q == WK_PREFIX_ADD) begin
            sums_we    = 1'b1;
            sums_waddr = child0;
            sums_wdata = rd_sum_q + (val_q << sh);
          end else if (walk_q == WK_PREFIX_SUM) begin
            res_d = sub_q ? res_q - term : res_q + term;
          end
        end
        if (!leaf) begin
          node_d = child;
          lvl_d  = lvl_q - LW'(1);
          xs_d   = xs_q << 1;
        end else if (second_q) begin
          second_d = 1'b0;
          node_d   = NW'(1);
          lvl_d    = LW'(LEVELS);
          x_d      = nx_q;
          xs_d     = nx_q;
          acc_d    = '0;
          case (walk_q)
            WK_POINT_READ: begin
              walk_d = WK_POINT_ADD;
              val_d  = {{(SUM_W-VAL_W){opv_q[VAL_W-1]}}, opv_q} - acc_q;
            end
            WK_PREFIX_ADD: val_d = '0 - val_q;
            default:       sub_d = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Hold the node stores
  always_ff @(posedge clk_i) begin
    if (sums_we) sums_mem[sums_waddr] <= sums_wdata;
    rd_sum_q <= sums_mem[sums_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tags_we) tags_mem[tags_waddr] <= tags_wdata;
    rd_tag_q <= tags_mem[tags_raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      walk_q      <= WK_PREFIX_SUM;
      second_q    <= 1'b0;
      sub_q       <= 1'b0;
      bad_q       <= 1'b0;
      clr_q       <= '0;
      node_q      <= NW'(1);
      lvl_q       <= '0;
      len_q       <= LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      walk_q   <= walk_d;
      second_q <= second_d;
      sub_q    <= sub_d;
      bad_q    <= bad_d;
      clr_q    <= clr_d;
      node_q   <= node_d;
      lvl_q    <= lvl_d;
      if (cfg_valid_i) len_q <= cfg_data_i;
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    xs_q   <= xs_d;
    nx_q   <= nx_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    val_q  <= val_d;
    prod_q <= prod_d;
    opv_q  <= opv_d;
    if (load_out) begin
      out_q.range_sum <= bad_q ? '0 : res_q;
      out_q.status    <= bad_q ? STATUS_BAD : STATUS_DONE;
    end
  end

`include "lazy_segment_tree_range_sum_macros.svh"

  `LSTRS_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != ST_IDLE, "accepted request did not start")
  `LSTRS_ASSERT_NOW(a_bad_sum_zero, out_valid_o && out_data_o.status == STATUS_BAD, out_data_o.range_sum == '0, "bad request carries a sum")
  `LSTRS_ASSERT_NOW(a_leaf_node, state_q == ST_RD && lvl_q == '0, node_q[NW-1], "walk reached leaf level off the leaf row")
  `LSTRS_ASSERT_NOW(a_out_from_done, $rose(out_valid_o), $past(state_q) == ST_DONE, "result loaded outside completion")

endmodule

`default_nettype wire

// File: bench/tb_lazy_segment_tree_range_sum.sv
// Self-checking bench for the lazy segment tree range-sum block.
// Depends on lstrs_pkg and the lazy_segment_tree_range_sum top level.
`timescale 1ns / 1ps

module tb_lazy_segment_tree_range_sum;
  import lstrs_pkg::*;

  localparam int unsigned N_ELEM   = 1024;
  localparam int unsigned N_RANDOM = 1200;
  localparam int unsigned DRAIN    = 200;

  // Directed stimulus row; chk marks a result typed in by hand
  typedef struct {
    logic [CFG_W-1:0] cfg;
    bit               do_cfg;
    in_t              req;
    bit               chk;
    out_t             res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // Shadow element array and length for prediction
  logic [SUM_W-1:0] elem_vals [N_ELEM];
  int unsigned      cur_len;
  out_t             sums_due [$];
  int               n_fail = 0;
  int unsigned      send_idle = 0;
  int unsigned      recv_stall = 0;

  lazy_segment_tree_range_sum #(.MAX_ELEMENTS(N_ELEM)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always #4 clk = ~clk;

  // Work out the result of one request and update the shadow array
  function automatic out_t predict_request(in_t r);
    out_t o;
    int unsigned len;
    logic [SUM_W-1:0] v;
    o   = '0;
    len = (cur_len > N_ELEM) ? N_ELEM : cur_len;
    v   = {{(SUM_W-VAL_W){r.operand_value[VAL_W-1]}}, r.operand_value};
    case (r.action)
      ACT_SET: begin
        if (r.range_low >= len) o.status = STATUS_BAD;
        else elem_vals[r.range_low] = v;
      end
      ACT_ADD, ACT_QUERY: begin
        if (r.range_high < r.range_low || r.range_high >= len) begin
          o.status = STATUS_BAD;
        end else begin
          for (int i = r.range_low; i <= r.range_high; i++) begin
            if (r.action == ACT_ADD) elem_vals[i] = elem_vals[i] + v;
            else o.range_sum = o.range_sum + elem_vals[i];
          end
        end
      end
      default: o.status = STATUS_BAD;
    endcase
    return o;
  endfunction

  // Receiver: stall at random, check each transfer against the oldest sum due
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sums_due.size() == 0) begin
        $error("result with nothing expected: sum %0d status %0d",
               out_data.range_sum, out_data.status);
        n_fail++;
      end else begin
        if (out_data.range_sum !== sums_due[0].range_sum) begin
          $error("range_sum expected %0d actual %0d",
                 sums_due[0].range_sum, out_data.range_sum);
          n_fail++;
        end
        if (out_data.status !== sums_due[0].status) begin
          $error("status expected %0d actual %0d",
                 sums_due[0].status, out_data.status);
          n_fail++;
        end
        void'(sums_due.pop_front());
      end
    end
  end

  task automatic write_length(logic [CFG_W-1:0] len);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cur_len = 32'(len);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send one request; keep valid high across back-to-back transfers
  task automatic send_request(in_t r, bit chk, out_t res);
    out_t o;
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    o = predict_request(r);
    if (chk) o = res;
    sums_due.push_back(o);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic in_t make_req(logic [1:0] a, int lo, int hi, int v);
    in_t r;
    r.action = a; r.range_low = IDX_W'(lo); r.range_high = IDX_W'(hi); r.operand_value = v;
    return r;
  endfunction

  // Mostly in-bounds ranges, some reversed or past the end, some action 3
  function automatic in_t random_req();
    in_t r;
    int unsigned lim;
    int unsigned lo;
    lim = (cur_len == 0) ? 1 : cur_len;
    r = '0;
    r.operand_value = $urandom();
    if ($urandom_range(99) < 10) begin
      r.action = 2'($urandom());
      r.range_low = IDX_W'($urandom());
      r.range_high = IDX_W'($urandom());
    end else begin
      r.action = 2'($urandom_range(2));
      lo = $urandom_range(lim - 1);
      r.range_low = IDX_W'(lo);
      if ($urandom_range(3) == 0)
        r.range_high = IDX_W'(lo + $urandom_range(lim - 1 - lo));
      else
        r.range_high = IDX_W'(lo + $urandom_range((lim - 1 - lo) < 15 ? lim - 1 - lo : 15));
    end
    return r;
  endfunction

  row_t plan [$];

  initial begin
    row_t rw;
    out_t none;
    for (int i = 0; i < N_ELEM; i++) elem_vals[i] = '0;
    cur_len = 32'(LEN_RESET);
    none = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    rw = '{cfg: '0, do_cfg: 0, req: make_req(ACT_QUERY, 0, 1023, 0), chk: 1, res: '0};
    plan.push_back(rw);
    rw.req = make_req(ACT_SET, 0, 0, 32'h7fffffff); rw.chk = 0; plan.push_back(rw);
    rw.req = make_req(ACT_SET, 1023, 0, 32'h80000000); plan.push_back(rw);
    rw.req = make_req(ACT_ADD, 0, 1023, -1); plan.push_back(rw);
    rw.req = make_req(ACT_QUERY, 0, 1023, 0); plan.push_back(rw);
    rw.req = make_req(ACT_QUERY, 1023, 1023, 0); plan.push_back(rw);
    rw.req = make_req(ACT_ADD, 5, 900, 32'h7fffffff); plan.push_back(rw);
    rw.req = make_req(ACT_SET, 7, 3, 12345); plan.push_back(rw);
    rw.req = make_req(ACT_QUERY, 3, 700, 0); plan.push_back(rw);
    rw.chk = 1; rw.res = '{range_sum: 0, status: STATUS_BAD};
    rw.req = make_req(ACT_QUERY, 9, 8, 0); plan.push_back(rw);
    rw.req = make_req(ACT_ADD, 9, 8, 1); plan.push_back(rw);
    rw.req = make_req(2'd3, 0, 10, 1); plan.push_back(rw);
    rw.do_cfg = 1; rw.cfg = 11'd1;
    rw.req = make_req(ACT_QUERY, 0, 1, 0); plan.push_back(rw);
    rw.do_cfg = 0;
    rw.req = make_req(ACT_SET, 1, 0, 1); plan.push_back(rw);
    rw.chk = 0; rw.req = make_req(ACT_QUERY, 0, 0, 0); plan.push_back(rw);
    rw.chk = 1; rw.do_cfg = 1; rw.cfg = 11'd0;
    rw.req = make_req(ACT_QUERY, 0, 0, 0); plan.push_back(rw);
    rw.do_cfg = 0; rw.req = make_req(ACT_SET, 0, 0, 5); plan.push_back(rw);
    rw.do_cfg = 1; rw.cfg = 11'd2047; rw.chk = 0;
    rw.req = make_req(ACT_QUERY, 0, 1023, 0); plan.push_back(rw);
    rw.do_cfg = 1; rw.cfg = 11'd1024;
    rw.req = make_req(ACT_QUERY, 2, 1022, 0); plan.push_back(rw);

    foreach (plan[i]) begin
      if (plan[i].do_cfg) begin
        drain_results();
        write_length(plan[i].cfg);
      end
      send_request(plan[i].req, plan[i].chk, plan[i].res);
    end

    // Random phases over lengths and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 54; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 54; end
        default: begin send_idle = 28; recv_stall = 28; end
      endcase
      case (ph)
        2: write_length(11'd1);
        3: write_length(11'd2);
        5: write_length(11'd37);
        6: write_length(11'd1024);
        default: ;
      endcase
      for (int k = 0; k < N_RANDOM / 8; k++) send_request(random_req(), 0, none);
    end

    drain_results();
    if (n_fail == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
